// ===== hdl/svu_pkg.sv =====
// Shared types, register codes, step codes and constants for the stereo VU meter.
// Depends on nothing; used by every module of the meter.
`default_nettype none

package svu_pkg;

	// Bar geometry
	localparam int          SEGMENTS = 32;
	localparam logic [5:0]  SEG_MAX  = 6'(SEGMENTS);

	// Q1.15 full scale
	localparam logic [15:0] Q_ONE = 16'd32768;

	// Divide by 1000: underestimate with 33554 / 2^25, then one correction step
	localparam logic [15:0] DIV_RECIP = 16'd33554;
	localparam logic [9:0]  MILLI     = 10'd1000;
	// gained level exceeds full scale once the product reaches 32769 * 1000
	localparam logic [28:0] SAT_LIMIT = 29'd32769000;

	// Rounding constant for Q1.15 weighting
	localparam logic [32:0] Q_HALF = 33'd16384;

	// Partial segment thresholds on the 15-bit fraction
	localparam logic [14:0] FRAC_FULL = 15'd24576;
	localparam logic [14:0] FRAC_HALF = 15'd8192;

	// Partial segment codes
	localparam logic [1:0] PART_DARK = 2'd0;
	localparam logic [1:0] PART_HALF = 2'd1;
	localparam logic [1:0] PART_FULL = 2'd2;

	// Peak marker codes
	localparam logic [1:0] SHOW_HIDDEN = 2'd0;
	localparam logic [1:0] SHOW_SOLID  = 2'd1;
	localparam logic [1:0] SHOW_DIMMED = 2'd2;

	// Register indexes (byte address 4 * index)
	localparam int         ADDR_W      = 5;
	localparam logic [2:0] REG_GAIN    = 3'd0;
	localparam logic [2:0] REG_GATE    = 3'd1;
	localparam logic [2:0] REG_ATTACK  = 3'd2;
	localparam logic [2:0] REG_RELEASE = 3'd3;
	localparam logic [2:0] REG_HOLD    = 3'd4;
	localparam logic [2:0] REG_FADE    = 3'd5;

	// Register reset values
	localparam logic [12:0] GAIN_RST    = 13'd1000;
	localparam logic [15:0] GATE_RST    = 16'd0;
	localparam logic [15:0] ATTACK_RST  = 16'd16384;
	localparam logic [15:0] RELEASE_RST = 16'd3277;
	localparam logic [15:0] HOLD_RST    = 16'd1000;
	localparam logic [15:0] FADE_RST    = 16'd500;

	// Sequencer steps, one per cycle, except that ST_OUT holds until the output register is free
	localparam int         STEP_W    = 4;
	localparam logic [3:0] ST_MUL    = 4'd0;
	localparam logic [3:0] ST_RECIP  = 4'd1;
	localparam logic [3:0] ST_FIX    = 4'd2;
	localparam logic [3:0] ST_DIFF   = 4'd3;
	localparam logic [3:0] ST_WEIGHT = 4'd4;
	localparam logic [3:0] ST_AVG    = 4'd5;
	localparam logic [3:0] ST_SEG    = 4'd6;
	localparam logic [3:0] ST_PEAK   = 4'd7;
	localparam logic [3:0] ST_OUT    = 4'd8;

	typedef struct packed {
		logic [12:0] gain_milli;
		logic [15:0] gate_level;
		logic [15:0] attack_coef;
		logic [15:0] release_coef;
		logic [15:0] hold_ms;
		logic [15:0] fade_ms;
	} cfg_t;

	typedef struct packed {
		logic              run;
		logic [STEP_W-1:0] step;
	} lane_ctl_t;

	typedef struct packed {
		logic [5:0] lit;
		logic [1:0] part;
		logic [5:0] pos;
		logic [1:0] show;
	} lane_res_t;

endpackage

`default_nettype wire

// ===== hdl/stereo_vu_meter_peak_hold.sv =====
// Stereo VU meter with peak hold: top level, register file and step sequencer.
// Depends on svu_pkg, svu_lane and svu_merge.
//
// Usage:
//   Input stream (s_*): one request per meter update, carrying the left and
//   right Q1.15 RMS levels and a millisecond timestamp.
//   Output stream (m_*): one request per input, carrying lit count, partial
//   segment, peak position and peak marker for each channel.
//   APB port: six 32-bit registers at byte addresses 0x00..0x14 (gain, gate,
//   attack, release, hold, fade); write only while the meter is idle.
// Each update walks a nine-step per-channel sequence (gain multiply,
// reciprocal divide by 1000, correction, smoothing multiply and update,
// segment split, peak hold, hand-over) before the next request may start,
// since the smoothed level feeds back; the hand-over step loads the result
// into the output register, which raises m_tvalid.
// Both channels run in parallel lanes on the same steps.
// Reset: registers return to their defaults; smoothed levels, peaks and peak
// time stamps clear to zero; no output is pending.
// Stall: a finished result waits in the output register; the next input is
// still taken and worked, and only its final hand-over waits for room.
`default_nettype none

module stereo_vu_meter_peak_hold (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // level_left[15:0], level_right[31:16], now_ms[63:32]
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// lit_left[5:0], part_left[7:6], peak_pos_left[13:8], peak_show_left[15:14],
	// lit_right[21:16], part_right[23:22], peak_pos_right[29:24], peak_show_right[31:30]
	output logic [31:0]      m_tdata,
	// register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [svu_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// ---------------- registers ----------------
	svu_pkg::cfg_t cfg_q;
	logic [2:0]    reg_idx;
	logic          wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_milli   <= svu_pkg::GAIN_RST;
			cfg_q.gate_level   <= svu_pkg::GATE_RST;
			cfg_q.attack_coef  <= svu_pkg::ATTACK_RST;
			cfg_q.release_coef <= svu_pkg::RELEASE_RST;
			cfg_q.hold_ms      <= svu_pkg::HOLD_RST;
			cfg_q.fade_ms      <= svu_pkg::FADE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				svu_pkg::REG_GAIN:    cfg_q.gain_milli   <= pwdata[12:0];
				svu_pkg::REG_GATE:    cfg_q.gate_level   <= pwdata[15:0];
				svu_pkg::REG_ATTACK:  cfg_q.attack_coef  <= pwdata[15:0];
				svu_pkg::REG_RELEASE: cfg_q.release_coef <= pwdata[15:0];
				svu_pkg::REG_HOLD:    cfg_q.hold_ms      <= pwdata[15:0];
				svu_pkg::REG_FADE:    cfg_q.fade_ms      <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			svu_pkg::REG_GAIN:    prdata = {19'b0, cfg_q.gain_milli};
			svu_pkg::REG_GATE:    prdata = {16'b0, cfg_q.gate_level};
			svu_pkg::REG_ATTACK:  prdata = {16'b0, cfg_q.attack_coef};
			svu_pkg::REG_RELEASE: prdata = {16'b0, cfg_q.release_coef};
			svu_pkg::REG_HOLD:    prdata = {16'b0, cfg_q.hold_ms};
			svu_pkg::REG_FADE:    prdata = {16'b0, cfg_q.fade_ms};
			default:              prdata = 32'd0;
		endcase
	end

	// ---------------- sequencer ----------------
	// busy from accept until the result is handed to the output register
	logic                       busy_q;
	logic [svu_pkg::STEP_W-1:0] step_q;
	logic [15:0]                level_left_q;
	logic [15:0]                level_right_q;
	logic [31:0]                now_q;
	logic                       accept;
	logic                       out_free;
	logic                       hand_over;
	svu_pkg::lane_ctl_t         ctl;

	assign s_tready  = !busy_q;
	assign accept    = s_tvalid && s_tready;
	assign hand_over = busy_q && (step_q == svu_pkg::ST_OUT) && out_free;
	assign ctl.run   = busy_q;
	assign ctl.step  = step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= svu_pkg::ST_MUL;
		end else if (accept) begin
			busy_q <= 1'b1;
			step_q <= svu_pkg::ST_MUL;
		end else if (busy_q) begin
			if (step_q != svu_pkg::ST_OUT) begin
				step_q <= step_q + 4'd1;
			end else if (out_free) begin
				busy_q <= 1'b0;
			end
		end
	end

	// request payload, held for the whole sequence
	always_ff @(posedge clk) begin
		if (accept) begin
			level_left_q  <= s_tdata[15:0];
			level_right_q <= s_tdata[31:16];
			now_q         <= s_tdata[63:32];
		end
	end

	// ---------------- lanes ----------------
	svu_pkg::lane_res_t res_left;
	svu_pkg::lane_res_t res_right;

	svu_lane u_lane_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cfg    (cfg_q),
		.level  (level_left_q),
		.now_ms (now_q),
		.res    (res_left)
	);

	svu_lane u_lane_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cfg    (cfg_q),
		.level  (level_right_q),
		.now_ms (now_q),
		.res    (res_right)
	);

	// ---------------- merge / output ----------------
	svu_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (hand_over),
		.res_left  (res_left),
		.res_right (res_right),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.free      (out_free)
	);

endmodule

`default_nettype wire

// ===== hdl/svu_lane.sv =====
// One channel of the meter: gain, gate, attack/release average, segments, peak hold.
// Depends on svu_pkg; stepped by the sequencer in the top level.
`default_nettype none

module svu_lane (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire svu_pkg::lane_ctl_t ctl,
	input  wire svu_pkg::cfg_t     cfg,
	input  wire logic [15:0]       level,
	input  wire logic [31:0]       now_ms,
	output svu_pkg::lane_res_t     res
);

	function automatic logic [15:0] clamp_coef(input logic [15:0] c);
		clamp_coef = (c > svu_pkg::Q_ONE) ? svu_pkg::Q_ONE : c;
	endfunction

	// datapath registers
	logic [28:0] prod_s1;
	logic        sat_s2;
	logic [15:0] quo_s2;
	logic [24:0] plo_s2;
	logic [15:0] gated_s3;
	logic        rise_s4;
	logic [15:0] diff_s4;
	logic [15:0] coef_s4;
	logic [15:0] delta_s5;
	logic [5:0]  lit_s7;
	logic [1:0]  part_s7;
	logic [31:0] age_s7;
	logic        grow_s7;
	svu_pkg::lane_res_t res_q;

	// channel state
	logic [15:0] avg_q;
	logic [5:0]  peak_q;
	logic [31:0] stamp_q;

	// reciprocal estimate of prod / 1000
	logic [40:0] recip_prod;
	assign recip_prod = {16'b0, prod_s1[24:0]} * {25'b0, svu_pkg::DIV_RECIP};

	// correction and gate
	logic [25:0] back;
	logic [25:0] rem;
	logic [15:0] quo_fix;
	logic [15:0] gained;
	assign back    = {10'b0, quo_s2} * {16'b0, svu_pkg::MILLI};
	assign rem     = {1'b0, plo_s2} - back;
	assign quo_fix = (rem >= {16'b0, svu_pkg::MILLI}) ? quo_s2 + 16'd1 : quo_s2;
	always_comb begin
		gained = sat_s2 ? svu_pkg::Q_ONE : quo_fix;
		if (gained < cfg.gate_level) begin
			gained = 16'd0;
		end
	end

	// weighted step toward the input, rounded
	logic [31:0] wprod;
	logic [32:0] wsum;
	assign wprod = {16'b0, coef_s4} * {16'b0, diff_s4};
	assign wsum  = {1'b0, wprod} + svu_pkg::Q_HALF;

	// segment split
	logic [21:0] scaled;
	logic [6:0]  lit_raw;
	logic [5:0]  lit_c;
	logic [14:0] frac;
	logic [1:0]  part_c;
	assign scaled  = {6'b0, avg_q} * 22'(svu_pkg::SEGMENTS);
	assign lit_raw = scaled[21:15];
	assign lit_c   = (lit_raw > {1'b0, svu_pkg::SEG_MAX}) ? svu_pkg::SEG_MAX : lit_raw[5:0];
	assign frac    = scaled[14:0];
	always_comb begin
		part_c = svu_pkg::PART_DARK;
		if (lit_c < svu_pkg::SEG_MAX) begin
			if (frac > svu_pkg::FRAC_FULL) begin
				part_c = svu_pkg::PART_FULL;
			end else if (frac > svu_pkg::FRAC_HALF) begin
				part_c = svu_pkg::PART_HALF;
			end
		end
	end

	// peak hold; a new peak restarts the age at zero
	logic [5:0]  pos_c;
	logic [31:0] age_eff;
	logic [16:0] span;
	logic        solid;
	logic        dimmed;
	logic [1:0]  show_c;
	assign pos_c   = grow_s7 ? lit_s7 : peak_q;
	assign age_eff = grow_s7 ? 32'd0 : age_s7;
	assign span    = {1'b0, cfg.hold_ms} + {1'b0, cfg.fade_ms};
	assign solid   = age_eff < {16'b0, cfg.hold_ms};
	assign dimmed  = !solid && (age_eff < {15'b0, span});
	always_comb begin
		if (solid) begin
			show_c = svu_pkg::SHOW_SOLID;
		end else if (dimmed) begin
			show_c = svu_pkg::SHOW_DIMMED;
		end else begin
			show_c = svu_pkg::SHOW_HIDDEN;
		end
		if (pos_c == 6'd0 || pos_c >= svu_pkg::SEG_MAX) begin
			show_c = svu_pkg::SHOW_HIDDEN;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.run) begin
			case (ctl.step)
				svu_pkg::ST_MUL: begin
					prod_s1 <= {13'b0, level} * {16'b0, cfg.gain_milli};
				end
				svu_pkg::ST_RECIP: begin
					sat_s2 <= prod_s1 >= svu_pkg::SAT_LIMIT;
					quo_s2 <= recip_prod[40:25];
					plo_s2 <= prod_s1[24:0];
				end
				svu_pkg::ST_FIX: begin
					gated_s3 <= gained;
				end
				svu_pkg::ST_DIFF: begin
					rise_s4 <= gated_s3 > avg_q;
					if (gated_s3 > avg_q) begin
						diff_s4 <= gated_s3 - avg_q;
						coef_s4 <= clamp_coef(cfg.attack_coef);
					end else begin
						diff_s4 <= avg_q - gated_s3;
						coef_s4 <= clamp_coef(cfg.release_coef);
					end
				end
				svu_pkg::ST_WEIGHT: begin
					delta_s5 <= wsum[30:15];
				end
				svu_pkg::ST_SEG: begin
					lit_s7  <= lit_c;
					part_s7 <= part_c;
					age_s7  <= now_ms - stamp_q;
					grow_s7 <= lit_c > peak_q;
				end
				svu_pkg::ST_PEAK: begin
					res_q.lit  <= lit_s7;
					res_q.part <= part_s7;
					res_q.pos  <= pos_c;
					res_q.show <= show_c;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q   <= 16'd0;
			peak_q  <= 6'd0;
			stamp_q <= 32'd0;
		end else if (ctl.run) begin
			if (ctl.step == svu_pkg::ST_AVG) begin
				avg_q <= rise_s4 ? avg_q + delta_s5 : avg_q - delta_s5;
			end
			if (ctl.step == svu_pkg::ST_PEAK) begin
				peak_q <= (!solid && !dimmed) ? lit_s7 : pos_c;
				if (grow_s7) begin
					stamp_q <= now_ms;
				end
			end
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

// ===== hdl/svu_merge.sv =====
// Merging stage: packs both lane results into one output request and holds it
// until taken. Depends on svu_pkg.
`default_nettype none

module svu_merge (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire svu_pkg::lane_res_t res_left,
	input  wire svu_pkg::lane_res_t res_right,
	input  wire logic               m_tready,
	output logic                    m_tvalid,
	output logic [31:0]             m_tdata,
	output logic                    free
);

	logic        valid_q;
	logic [31:0] data_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= {res_right.show, res_right.pos, res_right.part, res_right.lit,
				res_left.show, res_left.pos, res_left.part, res_left.lit};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

endmodule

`default_nettype wire

// ===== hdl/svu_check.sv =====
// Port-level checker for the stereo VU meter, bound to the top level.
// Depends on svu_pkg and stereo_vu_meter_peak_hold.
`default_nettype none

module svu_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);

	// one update in flight: input closes right after a request is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready while an update is in flight");

	// a new result appears exactly as the sequencer frees the input
	a_result_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> (s_tready && !$past(s_tready)))
		else $error("result without a finished update");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled output changed");

	// codes and counts in range
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[5:0] <= svu_pkg::SEG_MAX && m_tdata[21:16] <= svu_pkg::SEG_MAX
			&& m_tdata[7:6] != 2'd3 && m_tdata[23:22] != 2'd3
			&& m_tdata[15:14] != 2'd3 && m_tdata[31:30] != 2'd3))
		else $error("output field out of range");

	// marker hidden at the bottom of the bar
	a_peak_zero_hidden: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[13:8] == 6'd0 || m_tdata[29:24] == 6'd0)) |->
			((m_tdata[13:8] != 6'd0 || m_tdata[15:14] == svu_pkg::SHOW_HIDDEN)
			&& (m_tdata[29:24] != 6'd0 || m_tdata[31:30] == svu_pkg::SHOW_HIDDEN)))
		else $error("peak marker shown at segment zero");

endmodule

bind stereo_vu_meter_peak_hold svu_check u_svu_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
